@@ hdl/aopa_pkg.sv @@
package aopa_pkg;

  // Default configuration of the datapath
  localparam int unsigned PRICE_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF  = 12;
  localparam int unsigned MAX_STEPS_DEF  = 4096;
  localparam int unsigned MAX_PATHS_DEF  = 65536;

  // Accumulator word and shared divider
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned DIV_CNT_W = $clog2(ACC_W + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned STRIKE_W    = 24;
  localparam int unsigned STEPS_REG_W = 13;
  localparam int unsigned PATHS_REG_W = 17;

  localparam logic [STEPS_REG_W-1:0] STEPS_RST = STEPS_REG_W'(12);
  localparam logic [PATHS_REG_W-1:0] PATHS_RST = PATHS_REG_W'(1024);

  localparam logic OPT_CALL = 1'b0;
  localparam logic OPT_PUT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPTION_KIND,
    REG_STRIKE,
    REG_STEPS,
    REG_PATHS
  } cfg_reg_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] n_iter;
  } div_req_t;

endpackage

@@ hdl/aopa_price_if.sv @@
interface aopa_price_if import aopa_pkg::*; #(
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

@@ hdl/aopa_result_if.sv @@
interface aopa_result_if import aopa_pkg::*; #(
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [PRICE_BITS-1:0]   path_payoff;
  logic                    run_done;
  logic [PRICE_BITS-1:0]   mean_payoff;
  logic [2*PRICE_BITS-1:0] mean_sq_payoff;

  modport source (output valid, output path_payoff, output run_done, output mean_payoff,
                  output mean_sq_payoff, input ready);
  modport sink (input valid, input path_payoff, input run_done, input mean_payoff,
                input mean_sq_payoff, output ready);
endinterface

@@ hdl/aopa_cfg_if.sv @@
interface aopa_cfg_if import aopa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/aopa_div.sv @@
// Restoring divider, one quotient bit per cycle. Dividend arrives MSB-aligned.
module aopa_div import aopa_pkg::*; #(
  parameter int unsigned DIVISOR_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  input  logic [ACC_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [ACC_W-1:0]     quotient_o
);

  logic [ACC_W-1:0]     q_q;
  logic [DIVISOR_W-1:0] r_q;
  logic [DIVISOR_W-1:0] d_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    trial = {r_q, q_q[ACC_W-1]};
    diff  = trial - {1'b0, d_q};
    ge    = (trial >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.n_iter;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[ACC_W-2:0], ge};
      r_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

@@ hdl/asian_option_payoff_accumulator_core.sv @@
// Asian option payoff accumulator. A sample that does not close a path leaves ready high.
// A path-closing sample drops ready until its result enters the output register:
// one shared bit-serial divider forms the path mean, then a shift-add loop squares the payoff.
// The last path of a run adds two more divider passes, for the mean and mean-square payoff.
// Results leave through an output register; sampling resumes while a result waits.
// Reset (async, active low) restores register defaults and clears all counters and sums.
module asian_option_payoff_accumulator_core import aopa_pkg::*; #(
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned MAX_STEPS  = MAX_STEPS_DEF,
  parameter int unsigned MAX_PATHS  = MAX_PATHS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aopa_price_if.sink    price_i,
  aopa_result_if.source result_o,
  aopa_cfg_if.sink      cfg_i
);

  // Widths
  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned PATH_W = $clog2(MAX_PATHS + 1);
  // path sum, path mean and payoff all share this width
  localparam int unsigned PAY_W  = PRICE_BITS + STEP_W;
  localparam int unsigned PS2_W  = (PAY_W + PATH_W > ACC_W) ? ACC_W : PAY_W + PATH_W;
  localparam int unsigned DVS_W  = (STEP_W > PATH_W) ? STEP_W : PATH_W;
  localparam int unsigned MC_W   = $clog2(PAY_W + 1);

  localparam logic [STRIKE_W-1:0] STRIKE_RST = STRIKE_W'(64'd1 << FRAC_BITS);
  localparam logic [PAY_W-1:0]    PRICE_MASK = {{(PAY_W-PRICE_BITS){1'b0}}, {PRICE_BITS{1'b1}}};

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0; // taking samples
  localparam logic [2:0] S_MEAN = 3'd1; // divider: path sum / steps
  localparam logic [2:0] S_SQ   = 3'd2; // shift-add square of the payoff
  localparam logic [2:0] S_DMP  = 3'd3; // divider: payoff sum / paths
  localparam logic [2:0] S_DMSQ = 3'd4; // divider: squared sum / paths
  localparam logic [2:0] S_OUT  = 3'd5; // hand result to output register

  // Configuration registers
  logic                   opt_q;
  logic [STRIKE_W-1:0]    strike_q;
  logic [STEPS_REG_W-1:0] steps_q;
  logic [PATHS_REG_W-1:0] npaths_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_q    <= OPT_CALL;
      strike_q <= STRIKE_RST;
      steps_q  <= STEPS_RST;
      npaths_q <= PATHS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_OPTION_KIND: opt_q    <= cfg_i.data[0];
        REG_STRIKE:      strike_q <= cfg_i.data[STRIKE_W-1:0];
        REG_STEPS:       steps_q  <= cfg_i.data[STEPS_REG_W-1:0];
        REG_PATHS:       npaths_q <= cfg_i.data[PATHS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Counts clamped to 1..MAX
  logic [STEP_W-1:0] steps_c;
  logic [PATH_W-1:0] paths_c;

  always_comb begin
    if (steps_q == '0)                  steps_c = STEP_W'(1);
    else if (32'(steps_q) > MAX_STEPS) steps_c = STEP_W'(MAX_STEPS);
    else                                steps_c = STEP_W'(steps_q);
    if (npaths_q == '0)                 paths_c = PATH_W'(1);
    else if (32'(npaths_q) > MAX_PATHS) paths_c = PATH_W'(MAX_PATHS);
    else                                paths_c = PATH_W'(npaths_q);
  end

  // State
  logic [2:0]              state_q, state_d;
  logic [STEP_W-1:0]       pos_q, pos_d;
  logic [PAY_W-1:0]        psum_q, psum_d;
  logic [PATH_W-1:0]       paths_q, paths_d;
  logic [PS2_W-1:0]        paysum_q, paysum_d;
  logic [ACC_W-1:0]        sq_q, sq_d;
  logic [PAY_W-1:0]        pay_q, pay_d;
  logic [ACC_W-1:0]        mcand_q, mcand_d;
  logic [PAY_W-1:0]        mplier_q, mplier_d;
  logic [MC_W-1:0]         mcnt_q, mcnt_d;
  logic                    run_q, run_d;
  logic [PRICE_BITS-1:0]   mp_q, mp_d;
  logic [2*PRICE_BITS-1:0] msq_q, msq_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [PRICE_BITS-1:0]   out_pay_q, out_pay_d;
  logic                    out_run_q, out_run_d;
  logic [PRICE_BITS-1:0]   out_mp_q, out_mp_d;
  logic [2*PRICE_BITS-1:0] out_msq_q, out_msq_d;

  // Shared divider
  div_req_t         div_req;
  logic [ACC_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [ACC_W-1:0] div_quot;

  aopa_div #(
    .DIVISOR_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Payoff from the divided path mean
  logic [PAY_W-1:0]  mean;
  logic [PAY_W-1:0]  strike_k;
  logic [PAY_W-1:0]  payoff;
  logic [PATH_W-1:0] paths_next;
  logic              in_fire;

  always_comb begin
    mean     = div_quot[PAY_W-1:0];
    strike_k = PAY_W'(strike_q) & PRICE_MASK;
    if (opt_q == OPT_PUT) payoff = (strike_k > mean) ? strike_k - mean : '0;
    else                  payoff = (mean > strike_k) ? mean - strike_k : '0;
  end

  assign paths_next = paths_q + PATH_W'(1);
  assign in_fire    = price_i.valid && price_i.ready;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    psum_d      = psum_q;
    paths_d     = paths_q;
    paysum_d    = paysum_q;
    sq_d        = sq_q;
    pay_d       = pay_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    mcnt_d      = mcnt_q;
    run_d       = run_q;
    mp_d        = mp_q;
    msq_d       = msq_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_pay_d   = out_pay_q;
    out_run_d   = out_run_q;
    out_mp_d    = out_mp_q;
    out_msq_d   = out_msq_q;
    div_req     = '0;
    div_dividend = '0;
    div_divisor  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (pos_q == '0) begin
            // spot sample opens the path and is not averaged
            pos_d  = STEP_W'(1);
            psum_d = '0;
          end else begin
            psum_d = psum_q + PAY_W'(price_i.price);
            if (pos_q < steps_c) begin
              pos_d = pos_q + STEP_W'(1);
            end else begin
              // path closes; also catches a step count lowered mid-path
              pos_d          = '0;
              state_d        = S_MEAN;
              div_req.start  = 1'b1;
              div_req.n_iter = DIV_CNT_W'(PAY_W);
              div_dividend   = ACC_W'(psum_d) << (ACC_W - PAY_W);
              div_divisor    = DVS_W'(steps_c);
            end
          end
        end
      end
      S_MEAN: begin
        if (div_done) begin
          pay_d    = payoff;
          paysum_d = paysum_q + PS2_W'(payoff);
          mcand_d  = ACC_W'(payoff);
          mplier_d = payoff;
          mcnt_d   = MC_W'(PAY_W);
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        // square wraps modulo the accumulator word
        if (mplier_q[0]) sq_d = sq_q + mcand_q;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        mcnt_d   = mcnt_q - MC_W'(1);
        if (mcnt_q == MC_W'(1)) begin
          if (paths_next >= paths_c) begin
            run_d          = 1'b1;
            paths_d        = '0;
            state_d        = S_DMP;
            div_req.start  = 1'b1;
            div_req.n_iter = DIV_CNT_W'(PS2_W);
            div_dividend   = ACC_W'(paysum_q) << (ACC_W - PS2_W);
            div_divisor    = DVS_W'(paths_c);
          end else begin
            run_d   = 1'b0;
            paths_d = paths_next;
            mp_d    = '0;
            msq_d   = '0;
            state_d = S_OUT;
          end
        end
      end
      S_DMP: begin
        if (div_done) begin
          mp_d           = div_quot[PRICE_BITS-1:0];
          state_d        = S_DMSQ;
          div_req.start  = 1'b1;
          div_req.n_iter = DIV_CNT_W'(ACC_W);
          div_dividend   = sq_q;
          div_divisor    = DVS_W'(paths_c);
        end
      end
      S_DMSQ: begin
        if (div_done) begin
          msq_d   = div_quot[2*PRICE_BITS-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_pay_d   = pay_q[PRICE_BITS-1:0];
          out_run_d   = run_q;
          out_mp_d    = mp_q;
          out_msq_d   = msq_q;
          if (run_q) begin
            paysum_d = '0;
            sq_d     = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      psum_q      <= '0;
      paths_q     <= '0;
      paysum_q    <= '0;
      sq_q        <= '0;
      mcnt_q      <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      psum_q      <= psum_d;
      paths_q     <= paths_d;
      paysum_q    <= paysum_d;
      sq_q        <= sq_d;
      mcnt_q      <= mcnt_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q     <= pay_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    mp_q      <= mp_d;
    msq_q     <= msq_d;
    out_pay_q <= out_pay_d;
    out_run_q <= out_run_d;
    out_mp_q  <= out_mp_d;
    out_msq_q <= out_msq_d;
  end

  assign price_i.ready           = (state_q == S_IDLE);
  assign result_o.valid          = out_valid_q;
  assign result_o.path_payoff    = out_pay_q;
  assign result_o.run_done       = out_run_q;
  assign result_o.mean_payoff    = out_mp_q;
  assign result_o.mean_sq_payoff = out_msq_q;

endmodule
